// ===== rtl/wbss_pkg.sv =====
// types and constants shared by the wildcard byte signature scan unit
`default_nettype none

package wbss_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int COUNT_BITS_DEF        = 16;

    localparam int REG_PATTERN_BYTES = 16;
    localparam int ADDR_W            = 64;
    localparam int LEN_W             = 5;
    localparam int TOTAL_W           = 16;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 8'd3;

    typedef struct packed {
        logic [7:0]        code_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              section_last;
        logic              scan_last;
    } in_item_t;

    typedef struct packed {
        logic               match_found;
        logic [ADDR_W-1:0]  match_address;
        logic               scan_done;
        logic [ADDR_W-1:0]  resolved_address;
        logic [TOTAL_W-1:0] match_total;
        logic               ambiguous;
    } out_item_t;

    typedef struct packed {
        logic [REG_PATTERN_BYTES*8-1:0] pattern;
        logic [REG_PATTERN_BYTES-1:0]   care;
        logic [LEN_W-1:0]               length;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/wbss_cfg_regs.sv =====
// configuration register file of the scan unit
`default_nettype none

module wbss_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    input  wire logic [wbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wbss_pkg::cfg_t                           cfg
);

    logic [63:0]                  pattern_low_reg;
    logic [63:0]                  pattern_high_reg;
    logic [15:0]                  care_reg;
    logic [wbss_pkg::LEN_W-1:0]   length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            care_reg         <= '0;
            length_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wbss_pkg::REG_PATTERN_LOW:  pattern_low_reg  <= cfg_data;
                wbss_pkg::REG_PATTERN_HIGH: pattern_high_reg <= cfg_data;
                wbss_pkg::REG_CARE_MASK:    care_reg         <= cfg_data[15:0];
                wbss_pkg::REG_PATTERN_LEN:  length_reg       <= cfg_data[wbss_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cfg.care    = care_reg;
    assign cfg.length  = length_reg;

endmodule

`default_nettype wire

// ===== rtl/wbss_window.sv =====
// byte window of the current section and the parallel wildcard compare
`default_nettype none

module wbss_window #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire wbss_pkg::in_item_t item,
    input  wire wbss_pkg::cfg_t     cfg,
    output logic                    hit
);

    localparam int WIN_D  = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int PAT_W  = MAX_PATTERN_BYTES * 8;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_PATTERN_BYTES - 1);

    logic [7:0]        win_reg [WIN_D];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic [PAT_W-1:0]             pat_ext;
    logic [MAX_PATTERN_BYTES-1:0] care_ext;

    // positions beyond the register bits act as wildcards
    assign pat_ext  = PAT_W'(cfg.pattern);
    assign care_ext = MAX_PATTERN_BYTES'(cfg.care);

    always_comb
    begin
        logic [7:0] sel;
        int         len;
        len = int'(cfg.length);
        hit = (len >= 1) && (len <= MAX_PATTERN_BYTES) && (int'(fill_reg) + 1 >= len);
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            // byte that pattern position i lines up with
            sel = item.code_byte;
            for (int b = 1; b < MAX_PATTERN_BYTES; b++)
            begin
                if (i + b + 1 == len)
                begin
                    sel = win_reg[b-1];
                end
            end
            if ((i < len) && care_ext[i] && (sel != pat_ext[i*8 +: 8]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (item.section_last || item.scan_last)
        begin
            fill_next = '0;
        end
        else if (fill_reg < FILL_MAX)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (advance)
        begin
            fill_reg <= fill_next;
        end
    end

    // contents past the fill count are never compared, so no clear needed
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            win_reg[0] <= item.code_byte;
            for (int k = 1; k < WIN_D; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    fill_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("window fill beyond its limit");

    section_restart_a: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item.section_last || item.scan_last)) |=> (fill_reg == '0))
        else $error("window not emptied after section end");

    short_section_a: assert property (@(posedge clk) disable iff (!rst_n)
        (hit) |-> (int'(fill_reg) + 1 >= int'(cfg.length)))
        else $error("match across a section boundary");

endmodule

`default_nettype wire

// ===== rtl/wildcard_byte_signature_scan_unit.sv =====
// A request taken into the input register is compared there, and its result enters the
// result register when the held request advances.
// Throughput: one byte per cycle while result_stall is low; the window compare and the
// count update sit between the input and result registers, which advance together.
// Reset clears the configuration registers, window fill, match count, first address
// and both valid flags; the block accepts requests from the first edge after reset.
`default_nettype none

module wildcard_byte_signature_scan_unit #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int COUNT_BITS        = wbss_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                byte_valid,
    output logic                                     byte_stall,
    input  wire wbss_pkg::in_item_t                  byte_data,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output wbss_pkg::out_item_t                      result_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [wbss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    wbss_pkg::cfg_t      cfg;
    wbss_pkg::in_item_t  item_reg;
    wbss_pkg::out_item_t result_reg;
    wbss_pkg::out_item_t result_next;

    logic                              item_valid_reg;
    logic                              result_valid_reg;
    logic                              advance;
    logic                              hit;
    logic [COUNT_BITS-1:0]             count_reg;
    logic [COUNT_BITS-1:0]             count_next;
    logic [wbss_pkg::ADDR_W-1:0]       first_reg;
    logic [wbss_pkg::ADDR_W-1:0]       first_next;
    logic [wbss_pkg::ADDR_W-1:0]       start_addr;
    logic [wbss_pkg::TOTAL_W-1:0]      total;

    assign cfg_ready = 1'b1;

    wbss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbss_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .hit     (hit)
    );

    // the held request moves on whenever the result register is free or draining
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign byte_stall = item_valid_reg && !advance;

    assign start_addr = item_reg.byte_address - wbss_pkg::ADDR_W'(cfg.length) + 64'd1;

    always_comb
    begin
        count_next = count_reg;
        first_next = first_reg;
        if (hit)
        begin
            if (count_reg == '0)
            begin
                first_next = start_addr;
            end
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    generate
        if (COUNT_BITS > wbss_pkg::TOTAL_W)
        begin : g_total_sat
            assign total = (|count_next[COUNT_BITS-1:wbss_pkg::TOTAL_W]) ?
                           '1 : count_next[wbss_pkg::TOTAL_W-1:0];
        end
        else
        begin : g_total_ext
            assign total = wbss_pkg::TOTAL_W'(count_next);
        end
    endgenerate

    always_comb
    begin
        result_next.match_found      = hit;
        result_next.match_address    = hit ? start_addr : '0;
        result_next.scan_done        = item_reg.scan_last;
        result_next.resolved_address = (count_next == COUNT_BITS'(1)) ? first_next : '0;
        result_next.match_total      = total;
        result_next.ambiguous        = (count_next > COUNT_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            first_reg        <= '0;
        end
        else
        begin
            if (!byte_stall)
            begin
                item_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                count_reg <= item_reg.scan_last ? '0 : count_next;
                first_reg <= item_reg.scan_last ? '0 : first_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_reg <= byte_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    held_request_a: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && result_valid_reg && result_stall) |=> item_valid_reg)
        else $error("held request lost while result stalled");

    ambiguous_total_a: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.ambiguous) |-> (result_data.match_total > 16'd1))
        else $error("ambiguous flag with fewer than two matches");

    match_counted_a: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.match_found) |-> (result_data.match_total != 16'd0))
        else $error("match not counted");

    resolved_single_a: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_data.resolved_address != 64'd0)) |->
        (result_data.match_total == 16'd1))
        else $error("resolved address without a single match");

endmodule

`default_nettype wire

// ===== tb/sv/tb_wildcard_byte_signature_scan_unit.sv =====
// self-checking testbench for the wildcard byte signature scan unit
`default_nettype none

module tb_wildcard_byte_signature_scan_unit;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_PERCENT  = 38;
    localparam int WINDOW_DEPTH  = 15;
    localparam int PATTERN_MAX   = 16;

    class signature_match_model;
        bit [7:0]    history [WINDOW_DEPTH];
        bit [4:0]    fill;
        bit [15:0]   hits;
        bit [63:0]   first_start;
        bit [127:0]  pattern;
        bit [15:0]   care;
        bit [4:0]    length;
        wbss_pkg::out_item_t pending_scan_results [$];
        int          errors;
        int          bytes_taken;
        int          results_checked;
        int          matches_flagged;
        int          scans_closed;

        function new();
            for (int k = 0; k < WINDOW_DEPTH; k++)
                history[k] = 8'h00;
            fill = '0;
            hits = '0;
            first_start = '0;
            pattern = '0;
            care = '0;
            length = '0;
            errors = 0;
            bytes_taken = 0;
            results_checked = 0;
            matches_flagged = 0;
            scans_closed = 0;
        endfunction

        function void write_reg(logic [wbss_pkg::CFG_INDEX_W-1:0] idx,
                                logic [wbss_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                wbss_pkg::REG_PATTERN_LOW:  pattern[63:0]   = data;
                wbss_pkg::REG_PATTERN_HIGH: pattern[127:64] = data;
                wbss_pkg::REG_CARE_MASK:    care            = data[15:0];
                wbss_pkg::REG_PATTERN_LEN:  length          = data[4:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_scan_results.size();
        endfunction

        // works out the result for one accepted byte and advances the window
        function void take_byte(wbss_pkg::in_item_t it);
            wbss_pkg::out_item_t res;
            bit         hit;
            bit [7:0]   b;
            int         back;
            bit [63:0]  start;
            res = '0;
            start = '0;
            hit = (length >= 1) && (length <= PATTERN_MAX) && (int'(fill) + 1 >= int'(length));
            for (int k = 0; k < int'(length) && hit; k++)
            begin
                back = int'(length) - 1 - k;
                b = (back == 0) ? it.code_byte : history[back - 1];
                if (care[k] && b != pattern[8*k +: 8])
                    hit = 1'b0;
            end
            if (hit)
            begin
                start = it.byte_address - 64'(length) + 64'd1;
                if (hits == 0)
                    first_start = start;
                if (hits != 16'hFFFF)
                    hits++;
                matches_flagged++;
            end
            res.match_found      = hit;
            res.match_address    = start;
            res.scan_done        = it.scan_last;
            res.resolved_address = (hits == 1) ? first_start : 64'd0;
            res.match_total      = hits;
            res.ambiguous        = (hits > 1);
            for (int k = WINDOW_DEPTH - 1; k > 0; k--)
                history[k] = history[k - 1];
            history[0] = it.code_byte;
            if (fill < WINDOW_DEPTH)
                fill++;
            if (it.section_last || it.scan_last)
                fill = '0;
            if (it.scan_last)
            begin
                for (int k = 0; k < WINDOW_DEPTH; k++)
                    history[k] = 8'h00;
                hits = '0;
                first_start = '0;
                scans_closed++;
            end
            pending_scan_results = {pending_scan_results, res};
            bytes_taken++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void compare_result(wbss_pkg::out_item_t got);
            wbss_pkg::out_item_t want;
            results_checked++;
            if (pending_scan_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual %h", $time, got);
                return;
            end
            want = pending_scan_results.pop_front();
            compare_field("match_found", 64'(want.match_found), 64'(got.match_found));
            compare_field("match_address", want.match_address, got.match_address);
            compare_field("scan_done", 64'(want.scan_done), 64'(got.scan_done));
            compare_field("resolved_address", want.resolved_address, got.resolved_address);
            compare_field("match_total", 64'(want.match_total), 64'(got.match_total));
            compare_field("ambiguous", 64'(want.ambiguous), 64'(got.ambiguous));
        endfunction
    endclass

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              byte_valid   = 1'b0;
    logic                              byte_stall;
    wbss_pkg::in_item_t                byte_data    = '0;
    logic                              result_valid;
    logic                              result_stall = 1'b0;
    wbss_pkg::out_item_t               result_data;
    logic                              cfg_valid    = 1'b0;
    logic                              cfg_ready;
    logic [wbss_pkg::CFG_INDEX_W-1:0]  cfg_index    = '0;
    logic [wbss_pkg::CFG_DATA_W-1:0]   cfg_data     = '0;

    signature_match_model    sb;
    logic                    quiet        = 1'b0;
    int                      hold_token   = 0;
    int                      phase_count  = 0;
    int                      cycle_count  = 0;

    bit [127:0]              cur_pattern;
    bit [15:0]               cur_care;
    bit [4:0]                cur_len;

    wildcard_byte_signature_scan_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: check taken results, then pick the stall for the next edge
    initial
    begin : result_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.compare_result(result_data);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic wbss_pkg::in_item_t make_byte(bit [7:0] b, bit [63:0] a, bit sec_end,
                                                     bit scan_end);
        wbss_pkg::in_item_t it;
        it.code_byte    = b;
        it.byte_address = a;
        it.section_last = sec_end;
        it.scan_last    = scan_end;
        return it;
    endfunction

    task automatic send_byte(input wbss_pkg::in_item_t it);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.take_byte(it);
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [wbss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [wbss_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(input bit [127:0] pat, input bit [15:0] care, input bit [4:0] len);
        wait_idle();
        write_reg(wbss_pkg::REG_PATTERN_LOW, pat[63:0]);
        write_reg(wbss_pkg::REG_PATTERN_HIGH, pat[127:64]);
        write_reg(wbss_pkg::REG_CARE_MASK, 64'(care));
        write_reg(wbss_pkg::REG_PATTERN_LEN, 64'(len));
        cfg_valid <= 1'b0;
        cur_pattern = pat;
        cur_care    = care;
        cur_len     = len;
        phase_count++;
    endtask

    task automatic send_random_byte(input bit [7:0] b, inout bit [63:0] addr);
        if ($urandom_range(49) == 0)
            addr = {$urandom, $urandom};
        send_byte(make_byte(b, addr, $urandom_range(39) == 0, $urandom_range(59) == 0));
        addr++;
    endtask

    // mostly planted pattern copies with random wildcard content, the rest noise
    task automatic scan_phase(input int target);
        int          sent;
        bit [7:0]    b;
        bit [63:0]   addr;
        addr = {$urandom, $urandom};
        sent = 0;
        while (sent < target)
        begin
            if (cur_len >= 1 && cur_len <= PATTERN_MAX && $urandom_range(99) < 35)
            begin
                for (int k = 0; k < int'(cur_len); k++)
                begin
                    b = cur_care[k] ? cur_pattern[8*k +: 8] : 8'($urandom);
                    send_random_byte(b, addr);
                    sent++;
                end
            end
            else
            begin
                b = $urandom_range(1) ? 8'($urandom) : cur_pattern[8*$urandom_range(15) +: 8];
                send_random_byte(b, addr);
                sent++;
            end
        end
    endtask

    function automatic bit [4:0] random_length();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 5'd0;
        else if (r < 12)
            return 5'($urandom_range(17, 31));
        else if (r < 30)
            return 5'($urandom_range(9, 16));
        return 5'($urandom_range(1, 8));
    endfunction

    initial
    begin : stimulus
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern with every position a wildcard still never matches
        set_config(128'h0, 16'h0000, 5'd0);
        send_byte(make_byte(8'h00, 64'h0, 1'b0, 1'b0));
        send_byte(make_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1));

        // four byte pattern, start address wrapping below zero
        set_config({64'h0, 64'hFFFF_FFFF_EFBE_ADDE}, 16'h000F, 5'd4);
        send_byte(make_byte(8'hDE, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0));
        send_byte(make_byte(8'hAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
        send_byte(make_byte(8'hBE, 64'h0, 1'b0, 1'b0));
        send_byte(make_byte(8'hEF, 64'h1, 1'b0, 1'b0));
        // section ends inside the pattern, so no match may span it
        send_byte(make_byte(8'hDE, 64'h2, 1'b0, 1'b0));
        send_byte(make_byte(8'hAD, 64'h3, 1'b0, 1'b0));
        send_byte(make_byte(8'hBE, 64'h4, 1'b1, 1'b0));
        send_byte(make_byte(8'hEF, 64'h5, 1'b0, 1'b0));
        send_byte(make_byte(8'hDE, 64'h6, 1'b0, 1'b0));
        send_byte(make_byte(8'hAD, 64'h7, 1'b0, 1'b0));
        send_byte(make_byte(8'hBE, 64'h8, 1'b0, 1'b0));
        send_byte(make_byte(8'hEF, 64'h9, 1'b0, 1'b1));

        // single wildcard byte: every byte matches
        set_config({128{1'b1}}, 16'h0000, 5'd1);
        send_byte(make_byte(8'h5A, 64'h8000_0000_0000_0000, 1'b0, 1'b0));
        send_byte(make_byte(8'hA5, 64'h8000_0000_0000_0001, 1'b1, 1'b0));
        send_byte(make_byte(8'h3C, 64'h8000_0000_0000_0002, 1'b0, 1'b1));

        // overlong length never matches
        set_config(128'h0, 16'h0000, 5'd31);
        send_byte(make_byte(8'h00, 64'h10, 1'b0, 1'b0));
        send_byte(make_byte(8'h00, 64'h11, 1'b0, 1'b1));

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config({128{1'b1}}, 16'hFFFF, 5'd16);
                1: set_config(128'h0, 16'h0000, 5'd16);
                2: set_config({$urandom, $urandom, $urandom, $urandom}, 16'($urandom), 5'd17);
                default:
                    set_config({$urandom, $urandom, $urandom, $urandom},
                               ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom),
                               random_length());
            endcase
            if (p == 3)
            begin
                scan_phase(80);
                hold_token <= hold_token + 1;
                scan_phase(85);
            end
            else if (p == 4)
            begin
                scan_phase(80);
                wait_idle();
                scan_phase(85);
            end
            else if (p == 5)
            begin
                quiet <= 1'b1;
                scan_phase(165);
                quiet <= 1'b0;
            end
            else
                scan_phase(165);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("run covered %0d bytes over %0d register settings, %0d scans closed",
                 sb.bytes_taken, phase_count, sb.scans_closed);
        $display("%0d results checked, %0d matches flagged", sb.results_checked,
                 sb.matches_flagged);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
